FILE: design/abe_pkg.sv
// Package for the accumulator bytecode executor: opcodes, widths, lengths and shared types.
// No dependencies.
package abe_pkg;

  localparam int NumRegs = 32;
  localparam int RegIdxBits = 5;
  localparam int PcBits = 16;
  localparam int DataBits = 64;
  localparam int CountBits = 32;
  localparam int QueueDepth = 2;

  typedef enum logic [4:0] {
    OP_LDA_ZERO = 5'd0, OP_LDA_SMI = 5'd1, OP_LDA_UNDEF = 5'd2, OP_LDA_TRUE = 5'd3,
    OP_LDA_FALSE = 5'd4, OP_LDAR = 5'd5, OP_STAR = 5'd6, OP_MOV = 5'd7,
    OP_STAR_SHORT = 5'd8, OP_ADD = 5'd9, OP_SUB = 5'd10, OP_MUL = 5'd11,
    OP_DIV = 5'd12, OP_MOD = 5'd13, OP_ADD_IMM = 5'd14, OP_SUB_IMM = 5'd15,
    OP_NEGATE = 5'd16, OP_INC = 5'd17, OP_DEC = 5'd18, OP_EQ = 5'd19,
    OP_LT = 5'd20, OP_GT = 5'd21, OP_LE = 5'd22, OP_GE = 5'd23,
    OP_JUMP = 5'd24, OP_JUMP_TRUE = 5'd25, OP_JUMP_FALSE = 5'd26, OP_JUMP_LOOP = 5'd27,
    OP_RETURN = 5'd28, OP_RESTART = 5'd29, OP_ILL0 = 5'd30, OP_ILL1 = 5'd31
  } op_t;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_RETURNED = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  typedef enum logic [2:0] {
    EX_IDLE, EX_READ, EX_MUL, EX_DIV, EX_DIVFIX, EX_OUT
  } ex_state_t;

  // Decoded word as it travels from the front to the back.
  typedef struct packed {
    op_t op;
    logic [RegIdxBits-1:0] reg_a;
    logic [RegIdxBits-1:0] reg_b;
    logic signed [7:0] imm;
    logic [7:0] jump_offset;
    logic [2:0] len;
    logic is_div;
    logic is_mul;
  } dec_t;

  function automatic logic [2:0] op_len(input op_t op);
    logic [2:0] l;
    l = 3'd1;
    case (op)
      OP_LDA_SMI, OP_LDAR, OP_STAR, OP_NEGATE, OP_INC, OP_DEC,
      OP_JUMP, OP_JUMP_TRUE, OP_JUMP_FALSE: l = 3'd2;
      OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_ADD_IMM, OP_SUB_IMM,
      OP_EQ, OP_LT, OP_GT, OP_LE, OP_GE: l = 3'd3;
      OP_JUMP_LOOP: l = 3'd4;
      default: l = 3'd1;
    endcase
    return l;
  endfunction

endpackage

FILE: design/abe_if.sv
// Handshake interfaces for the executor's input, result and configuration channels.
// Depends on abe_pkg.
interface abe_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [4:0] op;
  logic [abe_pkg::RegIdxBits-1:0] reg_a;
  logic [abe_pkg::RegIdxBits-1:0] reg_b;
  logic signed [7:0] imm;
  logic [7:0] jump_offset;
  modport source (output valid, op, reg_a, reg_b, imm, jump_offset, input ready);
  modport sink (input valid, op, reg_a, reg_b, imm, jump_offset, output ready);
endinterface

interface abe_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [63:0] acc_value;
  logic [15:0] next_pc;
  logic [1:0] run_status;
  logic [31:0] instr_count;
  modport source (output valid, acc_value, next_pc, run_status, instr_count, input ready);
  modport sink (input valid, acc_value, next_pc, run_status, instr_count, output ready);
endinterface

interface abe_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: design/abe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module abe_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/abe_front.sv
// Front end: accepts input words, decodes length and class, and queues them for the back end.
// Depends on abe_pkg and abe_if.
module abe_front (
  input  logic            clk,
  input  logic            rst,
  abe_in_if.sink          in_ch,
  output abe_pkg::dec_t   q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  abe_pkg::dec_t slot [abe_pkg::QueueDepth];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push;
  abe_pkg::dec_t dec;

  assign in_ch.ready = (fill != 2'(abe_pkg::QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (fill != 2'd0);
  assign q_data = slot[rd_ptr];

  always_comb begin
    dec.op = abe_pkg::op_t'(in_ch.op);
    dec.reg_a = in_ch.reg_a;
    dec.reg_b = in_ch.reg_b;
    dec.imm = in_ch.imm;
    dec.jump_offset = in_ch.jump_offset;
    dec.len = abe_pkg::op_len(dec.op);
    dec.is_div = (dec.op == abe_pkg::OP_DIV) || (dec.op == abe_pkg::OP_MOD);
    dec.is_mul = (dec.op == abe_pkg::OP_MUL);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      fill <= 2'(abe_pkg::QueueDepth))
    else $error("queue overfilled");
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
      (fill == 2'(abe_pkg::QueueDepth)) |-> !in_ch.ready)
    else $error("ready while full");
endmodule

FILE: design/abe_divider.sv
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
// No dependencies.
module abe_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);
  logic [6:0] count;
  logic busy;
  logic [64:0] trial;
  logic [63:0] den;

  assign trial = {remainder, quotient[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        remainder <= trial[63:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        remainder <= {remainder[62:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end
    end
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
      end else if (busy) begin
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(busy))
    else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
      busy |-> !start)
    else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
      done |=> !done)
    else $error("done longer than one cycle");
endmodule

FILE: design/abe_back.sv
// Back end: architectural state, register file RAM, ALU, multiply and divide, result register.
// Depends on abe_pkg, abe_if, abe_ram and abe_divider.
module abe_back (
  input  logic            clk,
  input  logic            rst,
  input  abe_pkg::dec_t   q_data,
  input  logic            q_valid,
  output logic            q_pop,
  input  logic [15:0]     code_length,
  output logic            idle,
  abe_out_if.source       out_ch
);
  localparam int PB = abe_pkg::PcBits;

  abe_pkg::ex_state_t state, state_next;
  abe_pkg::dec_t cur;
  logic [63:0] acc;
  logic [PB-1:0] pc;
  logic [1:0] status;
  logic [31:0] count;
  logic [abe_pkg::NumRegs-1:0] reg_valid;

  logic [63:0] rdata, rval, prod;
  logic ra_ok;
  logic we;
  logic [abe_pkg::RegIdxBits-1:0] waddr;
  logic [63:0] wdata;
  logic [abe_pkg::RegIdxBits-1:0] raddr;

  logic [1:0] mul_step;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  logic div_start, div_done;
  logic [63:0] quo, rem, mag_n, mag_d;
  logic [63:0] quo_fix, rem_fix;
  logic [63:0] res_acc;
  logic [PB-1:0] res_pc;
  logic [1:0] res_status;
  logic commit;
  logic [63:0] imm64, jt;
  logic [PB-1:0] pc_seq, pc_fwd;
  logic pre_stop;

  // The register file address follows the popped word and then holds for the whole word.
  assign raddr = (state == abe_pkg::EX_IDLE) ? q_data.reg_a : cur.reg_a;

  abe_ram #(.Width(64), .Depth(abe_pkg::NumRegs)) u_rf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign ra_ok = reg_valid[cur.reg_a];
  assign rval = ra_ok ? rdata : 64'd0;
  assign mag_n = rval[63] ? (~rval + 64'd1) : rval;
  assign mag_d = acc[63] ? (~acc + 64'd1) : acc;

  abe_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mag_n), .divisor(mag_d),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  // A pending restart or a stop decides the word before any operand is needed.
  assign pre_stop = (status != abe_pkg::ST_RUN) || (pc >= PB'(code_length));
  assign imm64 = {{56{cur.imm[7]}}, cur.imm};
  assign pc_seq = pc + PB'(cur.len);
  assign pc_fwd = pc + PB'(cur.jump_offset);
  assign jt = 64'd0;

  // The low 64 bits of the product come from three 32-bit partial products, one per cycle.
  always_comb begin
    mul_x = rval[31:0];
    mul_y = acc[31:0];
    case (mul_step)
      2'd1: mul_y = acc[63:32];
      2'd2: mul_x = rval[63:32];
      default: ;
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  always_ff @(posedge clk) begin
    if (state == abe_pkg::EX_READ) begin
      mul_step <= 2'd0;
    end else if (state == abe_pkg::EX_MUL) begin
      mul_step <= mul_step + 2'd1;
      if (mul_step == 2'd0) prod <= mul_p;
      else prod <= prod + {mul_p[31:0], 32'd0};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      abe_pkg::EX_IDLE: if (q_valid) state_next = abe_pkg::EX_READ;
      abe_pkg::EX_READ: begin
        if (cur.op == abe_pkg::OP_RESTART || pre_stop) state_next = abe_pkg::EX_OUT;
        else if (cur.is_mul) state_next = abe_pkg::EX_MUL;
        else if (cur.is_div && acc != 64'd0) state_next = abe_pkg::EX_DIV;
        else state_next = abe_pkg::EX_OUT;
      end
      abe_pkg::EX_MUL: if (mul_step == 2'd2) state_next = abe_pkg::EX_OUT;
      abe_pkg::EX_DIV: if (div_done) state_next = abe_pkg::EX_DIVFIX;
      abe_pkg::EX_DIVFIX: state_next = abe_pkg::EX_OUT;
      abe_pkg::EX_OUT: if (!out_ch.valid || out_ch.ready) state_next = abe_pkg::EX_IDLE;
      default: state_next = abe_pkg::EX_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == abe_pkg::EX_IDLE) && q_valid;
    div_start = (state == abe_pkg::EX_READ) && cur.is_div && !pre_stop && acc != 64'd0 &&
                cur.op != abe_pkg::OP_RESTART;
    commit = (state == abe_pkg::EX_OUT) && (!out_ch.valid || out_ch.ready);
    idle = (state == abe_pkg::EX_IDLE) && !q_valid;
  end

  // Next architectural state, evaluated in EX_OUT (operands and unit results settled).
  always_comb begin
    res_acc = acc;
    res_pc = pc;
    res_status = status;
    we = 1'b0;
    waddr = cur.reg_a;
    wdata = acc;
    if (cur.op == abe_pkg::OP_RESTART) begin
      res_acc = '0;
      res_pc = '0;
      res_status = (code_length == 16'd0) ? abe_pkg::ST_PAST_END : abe_pkg::ST_RUN;
    end else if (status != abe_pkg::ST_RUN) begin
      res_status = status;
    end else if (pc >= PB'(code_length)) begin
      res_status = abe_pkg::ST_PAST_END;
    end else begin
      res_pc = pc_seq;
      case (cur.op)
        abe_pkg::OP_LDA_ZERO, abe_pkg::OP_LDA_UNDEF, abe_pkg::OP_LDA_FALSE: res_acc = '0;
        abe_pkg::OP_LDA_SMI: res_acc = imm64;
        abe_pkg::OP_LDA_TRUE: res_acc = 64'd1;
        abe_pkg::OP_LDAR: res_acc = rval;
        abe_pkg::OP_STAR: we = commit;
        abe_pkg::OP_MOV: begin
          we = commit;
          waddr = cur.reg_b;
          wdata = rval;
        end
        abe_pkg::OP_STAR_SHORT: begin
          we = commit;
          waddr = {1'b0, cur.reg_a[3:0]};
        end
        abe_pkg::OP_ADD: res_acc = rval + acc;
        abe_pkg::OP_SUB: res_acc = rval - acc;
        abe_pkg::OP_MUL: res_acc = prod;
        abe_pkg::OP_DIV: res_acc = (acc == 64'd0) ? 64'd0 : quo_fix;
        abe_pkg::OP_MOD: res_acc = (acc == 64'd0) ? 64'd0 : rem_fix;
        abe_pkg::OP_ADD_IMM: res_acc = acc + imm64;
        abe_pkg::OP_SUB_IMM: res_acc = acc - imm64;
        abe_pkg::OP_NEGATE: res_acc = ~acc + 64'd1;
        abe_pkg::OP_INC: res_acc = acc + 64'd1;
        abe_pkg::OP_DEC: res_acc = acc - 64'd1;
        abe_pkg::OP_EQ: res_acc = {63'd0, rval == acc};
        abe_pkg::OP_LT: res_acc = {63'd0, $signed(rval) < $signed(acc)};
        abe_pkg::OP_GT: res_acc = {63'd0, $signed(rval) > $signed(acc)};
        abe_pkg::OP_LE: res_acc = {63'd0, $signed(rval) <= $signed(acc)};
        abe_pkg::OP_GE: res_acc = {63'd0, $signed(rval) >= $signed(acc)};
        abe_pkg::OP_JUMP: res_pc = pc_fwd;
        abe_pkg::OP_JUMP_TRUE: if (acc == 64'd1) res_pc = pc_fwd;
        abe_pkg::OP_JUMP_FALSE: if (acc == jt) res_pc = pc_fwd;
        abe_pkg::OP_JUMP_LOOP: res_pc = pc - PB'(cur.jump_offset);
        abe_pkg::OP_RETURN: res_status = abe_pkg::ST_RETURNED;
        default: res_status = abe_pkg::ST_ILLEGAL;
      endcase
      if (res_status == abe_pkg::ST_RUN && res_pc >= PB'(code_length))
        res_status = abe_pkg::ST_PAST_END;
    end
    // Writes to a register index beyond the file are dropped.
    if (32'(waddr) >= abe_pkg::NumRegs) we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    // Sign fixup for the unsigned divider: quotient by sign xor, remainder by dividend.
    if (state == abe_pkg::EX_DIVFIX) begin
      quo_fix <= ((rval[63] ^ acc[63]) ? (~quo + 64'd1) : quo);
      rem_fix <= (rval[63] ? (~rem + 64'd1) : rem);
    end
    if (commit) begin
      out_ch.acc_value <= res_acc;
      out_ch.next_pc <= 16'(res_pc);
      out_ch.run_status <= res_status;
    end
    if (rst) begin
      state <= abe_pkg::EX_IDLE;
      acc <= '0;
      pc <= '0;
      status <= abe_pkg::ST_RUN;
      count <= '0;
      reg_valid <= '0;
      out_ch.valid <= 1'b0;
      out_ch.instr_count <= '0;
    end else begin
      state <= state_next;
      if (commit) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (commit) begin
        acc <= res_acc;
        pc <= res_pc;
        status <= res_status;
        if (cur.op == abe_pkg::OP_RESTART) begin
          count <= '0;
          reg_valid <= '0;
          out_ch.instr_count <= '0;
        end else if (status == abe_pkg::ST_RUN && pc < PB'(code_length)) begin
          count <= count + 32'd1;
          out_ch.instr_count <= count + 32'd1;
        end else begin
          out_ch.instr_count <= count;
        end
        if (we) reg_valid[waddr] <= 1'b1;
      end
    end
  end

  a_commit_in_out: assert property (@(posedge clk) disable iff (rst)
      commit |-> state == abe_pkg::EX_OUT)
    else $error("commit outside output state");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |=> state == abe_pkg::EX_READ)
    else $error("popped word not executed");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped");
endmodule

FILE: design/accumulator_bytecode_executor_top.sv
// Top level of the accumulator bytecode executor: front decode queue, back end and config register.
// Depends on abe_pkg, abe_if, abe_front and abe_back.

// Each input word is one decoded instruction; exactly one result word follows it, carrying the
// accumulator, next program counter, run status and instruction count. The back end runs one
// instruction at a time, stepping through queue pop, register file read and result register for
// most words; multiply adds a state that builds the low 64 bits from three 32-bit partial
// products, and a divide or modulo by a nonzero accumulator adds a one-bit-per-cycle divider
// and a sign fixup state. A two-word queue lets new words arrive while the back end works.
// code_length must be written only while the block is idle.
module accumulator_bytecode_executor_top (
  input logic clk,
  input logic rst,
  abe_in_if.sink in_ch,
  abe_out_if.source out_ch,
  abe_cfg_if.sink cfg
);
  abe_pkg::dec_t q_data;
  logic q_valid, q_pop, idle;
  logic [15:0] code_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= 16'hFFFF;
    end else if (cfg.valid && cfg.ready) begin
      code_length <= cfg.data;
    end
  end

  abe_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  abe_back u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .code_length(code_length), .idle(idle), .out_ch(out_ch)
  );

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
      (cfg.valid && cfg.ready) |-> idle)
    else $error("code_length written while busy");
  a_cfg_load: assert property (@(posedge clk) disable iff (rst)
      (cfg.valid && cfg.ready) |=> code_length == $past(cfg.data))
    else $error("code_length not loaded");
endmodule

FILE: verif/accumulator_bytecode_executor_top_tb.sv
// Self-checking testbench for the accumulator bytecode executor top level.
// Depends on abe_pkg, abe_if and the executor RTL; predicts each result word and compares it.
`timescale 1ns / 100ps

module accumulator_bytecode_executor_top_tb;

  typedef struct packed {
    abe_pkg::op_t op;
    logic [4:0] reg_a;
    logic [4:0] reg_b;
    logic signed [7:0] imm;
    logic [7:0] jump_offset;
  } instr_t;

  typedef struct packed {
    logic [63:0] acc_value;
    logic [15:0] next_pc;
    logic [1:0] run_status;
    logic [31:0] instr_count;
  } state_word_t;

  logic clk;
  logic rst;

  abe_in_if in_ch (clk);
  abe_out_if out_ch (clk);
  abe_cfg_if cfg (clk);

  accumulator_bytecode_executor_top u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  // Predictor state.
  logic [63:0] pred_acc;
  logic [63:0] pred_regs [abe_pkg::NumRegs];
  logic [15:0] pred_pc;
  logic [1:0] pred_status;
  logic [31:0] pred_count;
  logic [15:0] pred_code_length;

  instr_t pending_instrs[$];
  state_word_t expected_words[$];
  int mismatches = 0;
  int hold_off_cycles;
  bit long_hold;
  bit hold_started;
  bit in_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] signed_divide(input logic [63:0] n, input logic [63:0] d,
                                                input bit want_mod);
    logic [63:0] q;
    logic [63:0] r;
    if (d == 64'd0) return 64'd0;
    q = magnitude(n) / magnitude(d);
    r = magnitude(n) % magnitude(d);
    if (want_mod) return n[63] ? (~r + 64'd1) : r;
    return (n[63] ^ d[63]) ? (~q + 64'd1) : q;
  endfunction

  task automatic clear_machine();
    pred_acc = 64'd0;
    for (int i = 0; i < abe_pkg::NumRegs; i++) pred_regs[i] = 64'd0;
    pred_pc = 16'd0;
    pred_status = abe_pkg::ST_RUN;
    pred_count = 32'd0;
  endtask

  task automatic check_end();
    if (pred_status == abe_pkg::ST_RUN && pred_pc >= pred_code_length)
      pred_status = abe_pkg::ST_PAST_END;
  endtask

  task automatic execute_instr(input instr_t it);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] imm64;
    logic [15:0] ip;
    logic signed [63:0] sr;
    logic signed [63:0] sa;
    state_word_t w;
    a = pred_acc;
    r = pred_regs[it.reg_a];
    sr = r;
    sa = a;
    imm64 = {{56{it.imm[7]}}, it.imm};
    ip = pred_pc;
    if (it.op == abe_pkg::OP_RESTART) begin
      clear_machine();
      check_end();
    end else begin
      check_end();
      if (pred_status == abe_pkg::ST_RUN) begin
        pred_count++;
        pred_pc = (it.op == abe_pkg::OP_JUMP_LOOP) ? ip + 16'd4 :
                  ip + 16'(abe_pkg::op_len(it.op));
        case (it.op)
          abe_pkg::OP_LDA_ZERO, abe_pkg::OP_LDA_UNDEF, abe_pkg::OP_LDA_FALSE: pred_acc = 64'd0;
          abe_pkg::OP_LDA_SMI: pred_acc = imm64;
          abe_pkg::OP_LDA_TRUE: pred_acc = 64'd1;
          abe_pkg::OP_LDAR: pred_acc = r;
          abe_pkg::OP_STAR: pred_regs[it.reg_a] = a;
          abe_pkg::OP_MOV: pred_regs[it.reg_b] = r;
          abe_pkg::OP_STAR_SHORT: pred_regs[{1'b0, it.reg_a[3:0]}] = a;
          abe_pkg::OP_ADD: pred_acc = r + a;
          abe_pkg::OP_SUB: pred_acc = r - a;
          abe_pkg::OP_MUL: pred_acc = r * a;
          abe_pkg::OP_DIV: pred_acc = signed_divide(r, a, 1'b0);
          abe_pkg::OP_MOD: pred_acc = signed_divide(r, a, 1'b1);
          abe_pkg::OP_ADD_IMM: pred_acc = a + imm64;
          abe_pkg::OP_SUB_IMM: pred_acc = a - imm64;
          abe_pkg::OP_NEGATE: pred_acc = ~a + 64'd1;
          abe_pkg::OP_INC: pred_acc = a + 64'd1;
          abe_pkg::OP_DEC: pred_acc = a - 64'd1;
          abe_pkg::OP_EQ: pred_acc = (r == a) ? 64'd1 : 64'd0;
          abe_pkg::OP_LT: pred_acc = (sr < sa) ? 64'd1 : 64'd0;
          abe_pkg::OP_GT: pred_acc = (sr > sa) ? 64'd1 : 64'd0;
          abe_pkg::OP_LE: pred_acc = (sr <= sa) ? 64'd1 : 64'd0;
          abe_pkg::OP_GE: pred_acc = (sr >= sa) ? 64'd1 : 64'd0;
          abe_pkg::OP_JUMP: pred_pc = ip + 16'(it.jump_offset);
          abe_pkg::OP_JUMP_TRUE: if (a == 64'd1) pred_pc = ip + 16'(it.jump_offset);
          abe_pkg::OP_JUMP_FALSE: if (a == 64'd0) pred_pc = ip + 16'(it.jump_offset);
          abe_pkg::OP_JUMP_LOOP: pred_pc = ip - 16'(it.jump_offset);
          abe_pkg::OP_RETURN: pred_status = abe_pkg::ST_RETURNED;
          default: pred_status = abe_pkg::ST_ILLEGAL;
        endcase
        check_end();
      end
    end
    w.acc_value = pred_acc;
    w.next_pc = pred_pc;
    w.run_status = pred_status;
    w.instr_count = pred_count;
    expected_words.push_back(w);
  endtask

  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Driver: offers words from pending_instrs with random gaps.
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the word until it is taken.
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_instrs.size() > 0) begin
      in_ch.valid <= 1'b1;
      {in_ch.op, in_ch.reg_a, in_ch.reg_b, in_ch.imm, in_ch.jump_offset} <=
        pending_instrs.pop_front();
      send_gap <= random_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_machine();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready)
        execute_instr(instr_t'({in_ch.op, in_ch.reg_a, in_ch.reg_b, in_ch.imm,
                                in_ch.jump_offset}));
    end
  end

  // Receiver stalls; one long stretch with ready low starts once long_hold is raised.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= 0;
      hold_started <= 1'b0;
    end else if (long_hold && !hold_started) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= 300;
      hold_started <= 1'b1;
    end else if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else out_ch.ready <= (random_gap() == 0) || ($urandom_range(0, 2) != 0);
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    state_word_t exp_w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word at %0t", $realtime);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_ch.acc_value !== exp_w.acc_value || out_ch.next_pc !== exp_w.next_pc ||
            out_ch.run_status !== exp_w.run_status ||
            out_ch.instr_count !== exp_w.instr_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: acc %h/%h pc %h/%h status %0d/%0d count %0d/%0d (exp/act)",
                     exp_w.acc_value, out_ch.acc_value, exp_w.next_pc, out_ch.next_pc,
                     exp_w.run_status, out_ch.run_status, exp_w.instr_count,
                     out_ch.instr_count);
        end
      end
    end
  end

  function automatic instr_t make_instr(input abe_pkg::op_t op, input logic [4:0] ra,
                                        input logic [4:0] rb, input logic [7:0] imm,
                                        input logic [7:0] off);
    instr_t it;
    it.op = op;
    it.reg_a = ra;
    it.reg_b = rb;
    it.imm = imm;
    it.jump_offset = off;
    return it;
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    int p;
    it = instr_t'(31'($urandom));
    p = $urandom_range(0, 99);
    // Restart and stop-causing words are kept rare so most words execute.
    if (p < 3) it.op = abe_pkg::OP_RESTART;
    else if (p < 5) it.op = abe_pkg::op_t'($urandom_range(28, 31));
    else if (p < 8) it.op = ($urandom_range(0, 1) != 0) ? abe_pkg::OP_DIV : abe_pkg::OP_MOD;
    else it.op = abe_pkg::op_t'($urandom_range(0, 27));
    if ($urandom_range(0, 1) != 0) it.reg_a = 5'($urandom_range(0, 3));
    if ((it.op == abe_pkg::OP_JUMP || it.op == abe_pkg::OP_JUMP_LOOP) &&
        $urandom_range(0, 3) != 0)
      it.jump_offset = 8'($urandom_range(0, 8));
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_instrs.size() > 0 || in_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_code_length(input logic [15:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    pred_code_length = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] lengths [5];
    cfg.valid = 1'b0;
    cfg.data = 16'd0;
    long_hold = 1'b0;
    pred_code_length = 16'hFFFF;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: every opcode but OP_ILL0, field extremes, divide corner cases.
    pending_instrs.push_back(make_instr(abe_pkg::OP_LDA_SMI, 5'd0, 5'd0, 8'h80, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_STAR, 5'd31, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_LDA_SMI, 5'd0, 5'd0, 8'h7F, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_STAR_SHORT, 5'd31, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_MOV, 5'd31, 5'd1, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_LDA_ZERO, 5'd0, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_DIV, 5'd1, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_INC, 5'd0, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_SUB_IMM, 5'd0, 5'd0, 8'h02, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_STAR, 5'd2, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_LDA_TRUE, 5'd0, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_JUMP_TRUE, 5'd0, 5'd0, 8'd0, 8'd5));
    for (int k = 0; k < 32; k++) begin
      if (abe_pkg::op_t'(k) != abe_pkg::OP_RESTART && abe_pkg::op_t'(k) != abe_pkg::OP_RETURN &&
          k < 30)
        pending_instrs.push_back(make_instr(abe_pkg::op_t'(k), 5'($urandom), 5'($urandom),
                                            8'($urandom), 8'd3));
    end
    pending_instrs.push_back(make_instr(abe_pkg::OP_RETURN, 5'd0, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_INC, 5'd0, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_RESTART, 5'd0, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_ILL1, 5'd31, 5'd31, 8'hFF, 8'hFF));
    pending_instrs.push_back(make_instr(abe_pkg::OP_RESTART, 5'd0, 5'd0, 8'd0, 8'd0));
    pending_instrs.push_back(make_instr(abe_pkg::OP_JUMP_LOOP, 5'd0, 5'd0, 8'd0, 8'hFF));
    pending_instrs.push_back(make_instr(abe_pkg::OP_RESTART, 5'd0, 5'd0, 8'd0, 8'd0));
    wait_idle();

    // Long receiver hold-off while the sender keeps offering words.
    for (int k = 0; k < 12; k++) pending_instrs.push_back(random_instr());
    long_hold = 1'b1;
    wait_idle();

    lengths[0] = 16'd0;
    lengths[1] = 16'd1;
    lengths[2] = 16'd40;
    lengths[3] = 16'd300;
    lengths[4] = 16'hFFFF;
    for (int ph = 0; ph < 5; ph++) begin
      write_code_length(lengths[ph]);
      pending_instrs.push_back(make_instr(abe_pkg::OP_RESTART, 5'd0, 5'd0, 8'd0, 8'd0));
      for (int k = 0; k < 140; k++) pending_instrs.push_back(random_instr());
      wait_idle();
    end

    if (mismatches == 0) $display("accumulator_bytecode_executor_top_tb OK");
    else $display("accumulator_bytecode_executor_top_tb NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("accumulator_bytecode_executor_top_tb NOT OK");
    $finish;
  end

endmodule
